// File: rtl/first_fit_wait_queue_unit_assert.svh
// assertion macros for the first-fit wait queue unit
// expects signals clk and rst in the scope of use
`ifndef FIRST_FIT_WAIT_QUEUE_UNIT_ASSERT_SVH
`define FIRST_FIT_WAIT_QUEUE_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define FFWQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FFWQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ffwq_pkg.sv
// shared types and constants of the first-fit wait queue unit
// no dependencies
package ffwq_pkg;

  localparam int SIZE_BITS = 8;
  localparam int NAME_LOW_W = 64;
  localparam int NAME_HIGH_W = 8;
  localparam int DATA_W = 80;
  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_SEATED    = 3'd3,
    ST_NO_FIT    = 3'd4
  } status_t;

  typedef struct packed {
    logic [NAME_HIGH_W-1:0] name_high;
    logic [NAME_LOW_W-1:0]  name_low;
    logic [SIZE_BITS-1:0]   size;
  } entry_t;

  typedef struct packed {
    logic                   seat;
    logic [NAME_LOW_W-1:0]  name_low;
    logic [NAME_HIGH_W-1:0] name_high;
    logic [SIZE_BITS-1:0]   size;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [NAME_LOW_W-1:0]  name_low;
    logic [NAME_HIGH_W-1:0] name_high;
    logic [SIZE_BITS-1:0]   size;
  } res_t;

  // zero every byte after the first zero byte of the nine-byte name
  function automatic entry_t canon_entry(input logic [NAME_LOW_W-1:0] lo,
                                         input logic [NAME_HIGH_W-1:0] hi,
                                         input logic [SIZE_BITS-1:0] size);
    entry_t e;
    logic   ended;
    ended = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (lo[8*b +: 8] == 8'd0) ended = 1'b1;
      e.name_low[8*b +: 8] = ended ? 8'd0 : lo[8*b +: 8];
    end
    e.name_high = ended ? '0 : hi;
    e.size = size;
    return e;
  endfunction

endpackage

// File: rtl/ffwq_mem.sv
// entry store of the first-fit wait queue: one write port, one registered read port
// no dependencies
module ffwq_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4,
  parameter int DW = 80
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ffwq_ctrl.sv
// request sequencer of the first-fit wait queue: scan, append and compaction
// depends on ffwq_pkg, ffwq_mem and first_fit_wait_queue_unit_assert.svh
`include "first_fit_wait_queue_unit_assert.svh"

module ffwq_ctrl #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ffwq_pkg::req_t  req,
  output logic            res_valid,
  input  logic            res_ready,
  output ffwq_pkg::res_t  res
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(ffwq_pkg::entry_t);

  typedef enum logic [1:0] {IDLE, SCAN, SHIFT, DONE} state_t;

  state_t           state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    rd_idx, rd_idx_next;
  logic [CW-1:0]    rd_pos, rd_pos_next;
  logic             rd_pend, rd_pend_next;
  logic             seat, seat_next;
  ffwq_pkg::entry_t key, key_next;
  ffwq_pkg::res_t   res_next;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  ffwq_pkg::entry_t mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [EW-1:0]    mem_rdata;
  ffwq_pkg::entry_t rd_entry;
  ffwq_pkg::entry_t new_key;

  logic [CW-1:0]    count_m1;
  logic [CW-1:0]    pos_m1;
  logic [CW-1:0]    waddr_ext;
  logic             issue;
  logic             hit;

  ffwq_mem #(
    .DEPTH(QUEUE_DEPTH),
    .AW(AW),
    .DW(EW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rd_entry = ffwq_pkg::entry_t'(mem_rdata);
  assign new_key = ffwq_pkg::canon_entry(req.name_low, req.name_high, req.size);
  assign count_m1 = count - CW'(1);
  assign pos_m1 = rd_pos - CW'(1);
  assign issue = rd_idx < count;
  assign hit = seat ? (rd_entry.size <= key.size)
                    : (rd_entry.name_low == key.name_low &&
                       rd_entry.name_high == key.name_high);
  assign mem_raddr = rd_idx[AW-1:0];
  assign in_ready = (state == IDLE);
  assign res_valid = (state == DONE);
  assign waddr_ext = CW'(mem_waddr);

  always_comb begin
    state_next = state;
    count_next = count;
    rd_idx_next = rd_idx;
    rd_pos_next = rd_pos;
    rd_pend_next = 1'b0;
    seat_next = seat;
    key_next = key;
    res_next = res;
    mem_we = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = key;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          key_next = new_key;
          seat_next = req.seat;
          rd_idx_next = '0;
          res_next = '0;
          if (count == '0) begin
            if (req.seat) begin
              res_next.status = ffwq_pkg::ST_NO_FIT;
            end else begin
              mem_we = 1'b1;
              mem_wdata = new_key;
              count_next = CW'(1);
              res_next.status = ffwq_pkg::ST_ADDED;
            end
            state_next = DONE;
          end else begin
            state_next = SCAN;
          end
        end
      end
      SCAN: begin
        rd_pend_next = issue;
        rd_pos_next = rd_idx;
        if (issue) rd_idx_next = rd_idx + CW'(1);
        if (rd_pend) begin
          if (hit) begin
            if (seat) begin
              res_next.status = ffwq_pkg::ST_SEATED;
              res_next.name_low = rd_entry.name_low;
              res_next.name_high = rd_entry.name_high;
              res_next.size = rd_entry.size;
              rd_idx_next = rd_pos + CW'(1);
              rd_pend_next = 1'b0;
              state_next = SHIFT;
            end else begin
              res_next.status = ffwq_pkg::ST_DUPLICATE;
              state_next = DONE;
            end
          end else if (rd_pos == count_m1) begin
            if (seat) begin
              res_next.status = ffwq_pkg::ST_NO_FIT;
            end else if (count == CW'(QUEUE_DEPTH)) begin
              res_next.status = ffwq_pkg::ST_FULL;
            end else begin
              mem_we = 1'b1;
              count_next = count + CW'(1);
              res_next.status = ffwq_pkg::ST_ADDED;
            end
            state_next = DONE;
          end
        end
      end
      SHIFT: begin
        rd_pend_next = issue;
        rd_pos_next = rd_idx;
        if (issue) rd_idx_next = rd_idx + CW'(1);
        if (rd_pend) begin
          mem_we = 1'b1;
          mem_waddr = pos_m1[AW-1:0];
          mem_wdata = rd_entry;
        end
        if (!issue && !rd_pend) begin
          count_next = count_m1;
          state_next = DONE;
        end
      end
      DONE: begin
        if (res_ready) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rd_pend <= rd_pend_next;
    end
    rd_idx <= rd_idx_next;
    rd_pos <= rd_pos_next;
    seat <= seat_next;
    key <= key_next;
    res <= res_next;
  end

  `FFWQ_ASSERT_ALWAYS(a_count_bound, count <= CW'(QUEUE_DEPTH), "entry count above depth")
  `FFWQ_ASSERT_ALWAYS(a_write_in_range, !mem_we || waddr_ext <= count, "write beyond tail")
  `FFWQ_ASSERT_NEXT(a_count_step, 1'b1, count == $past(count) || count == $past(count) + CW'(1) || count + CW'(1) == $past(count), "count moved by more than one")
  `FFWQ_ASSERT_NEXT(a_shift_only_after_seat, state == SCAN && state_next == SHIFT, seat && res.status == ffwq_pkg::ST_SEATED, "compaction without seated entry")

endmodule

// File: rtl/first_fit_wait_queue_unit.sv
// channel  dir  data fields (low bit up)                          side band
// s_*      in   name_low[63:0] name_high[71:64] size_value[79:72]  tuser: req_type
// m_*      out  out_name_low[63:0] out_name_high[71:64] out_size   tuser: status
// with count entries queued a request holds the sequencer while it scans them, and a seat
// that removes an entry then shifts each later one down; an empty store needs no scan; one
// entry is compared or moved per cycle through the registered read port of the store
// reset clears the entry count and the sequencer; stored entries are not cleared
// a finished result waits in the output register while the next request is taken
// top level of the first-fit wait queue; depends on ffwq_pkg and ffwq_ctrl
module first_fit_wait_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ffwq_pkg::DATA_W-1:0]   s_tdata,   // name_low, name_high, size_value
  input  logic                          s_tuser,   // req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ffwq_pkg::DATA_W-1:0]   m_tdata,   // out_name_low, out_name_high, out_size
  output logic [ffwq_pkg::STATUS_W-1:0] m_tuser    // status
);

  ffwq_pkg::req_t req;
  ffwq_pkg::res_t res;
  logic           res_valid;
  logic           res_ready;

  assign req.seat = s_tuser;
  assign req.name_low = s_tdata[63:0];
  assign req.name_high = s_tdata[71:64];
  assign req.size = s_tdata[79:72];

  assign res_ready = !m_tvalid || m_tready;

  ffwq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .req(req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
    if (res_ready && res_valid) begin
      m_tdata <= {res.size, res.name_high, res.name_low};
      m_tuser <= res.status;
    end
  end

endmodule

// File: verif/ffwq_reply_checker.sv
// reply checker for the first-fit wait queue unit: mirrors the waiting line,
// predicts each reply and compares it field by field; depends on ffwq_pkg
module ffwq_reply_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [ffwq_pkg::DATA_W-1:0]   s_tdata,   // name_low, name_high, size_value
  input  logic                          s_tuser,   // req_type
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [ffwq_pkg::DATA_W-1:0]   m_tdata,   // out_name_low, out_name_high, out_size
  input  logic [ffwq_pkg::STATUS_W-1:0] m_tuser,   // status
  output int                            fail_count,
  output int                            replies_owed
);

  typedef struct packed {
    logic [ffwq_pkg::NAME_HIGH_W-1:0] hi;
    logic [ffwq_pkg::NAME_LOW_W-1:0]  lo;
    logic [ffwq_pkg::SIZE_BITS-1:0]   amount;
  } party_t;

  party_t         waiting_line[$];
  ffwq_pkg::res_t owed_replies[$];
  ffwq_pkg::res_t oldest_owed;

  initial begin
    fail_count = 0;
    replies_owed = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < 40)
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  // a name stops at its first zero byte in the low eight bytes
  function automatic logic [71:0] trimmed_name(input logic [63:0] lo, input logic [7:0] hi);
    logic [71:0] name;
    int          cut;
    name = {hi, lo};
    cut = 9;
    for (int b = 7; b >= 0; b--)
      if (lo[8*b +: 8] == 8'h00) cut = b;
    for (int b = 0; b < 9; b++)
      if (b >= cut) name[8*b +: 8] = 8'h00;
    return name;
  endfunction

  function automatic ffwq_pkg::res_t serve_request(input logic seat, input logic [63:0] lo,
                                                   input logic [7:0] hi,
                                                   input logic [7:0] amount);
    ffwq_pkg::res_t reply;
    logic [71:0]    name;
    party_t         party;
    int             pick;
    reply = '0;
    if (!seat) begin
      name = trimmed_name(lo, hi);
      reply.status = ffwq_pkg::ST_ADDED;
      foreach (waiting_line[i])
        if ({waiting_line[i].hi, waiting_line[i].lo} == name)
          reply.status = ffwq_pkg::ST_DUPLICATE;
      if (reply.status == ffwq_pkg::ST_ADDED && waiting_line.size() >= QUEUE_DEPTH)
        reply.status = ffwq_pkg::ST_FULL;
      if (reply.status == ffwq_pkg::ST_ADDED) begin
        party.hi = name[71:64];
        party.lo = name[63:0];
        party.amount = amount;
        waiting_line.push_back(party);
      end
    end else begin
      pick = -1;
      foreach (waiting_line[i])
        if (pick < 0 && waiting_line[i].amount <= amount) pick = i;
      if (pick < 0) begin
        reply.status = ffwq_pkg::ST_NO_FIT;
      end else begin
        reply.status = ffwq_pkg::ST_SEATED;
        reply.name_low = waiting_line[pick].lo;
        reply.name_high = waiting_line[pick].hi;
        reply.size = waiting_line[pick].amount;
        waiting_line.delete(pick);
      end
    end
    return reply;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      waiting_line.delete();
      owed_replies.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_replies.size() == 0) begin
          report_mismatch("reply with none owed, status", 64'(m_tuser), 64'd0);
        end else begin
          oldest_owed = owed_replies.pop_front();
          if (m_tuser !== oldest_owed.status)
            report_mismatch("status", 64'(m_tuser), 64'(oldest_owed.status));
          if (m_tdata[63:0] !== oldest_owed.name_low)
            report_mismatch("out_name_low", m_tdata[63:0], oldest_owed.name_low);
          if (m_tdata[71:64] !== oldest_owed.name_high)
            report_mismatch("out_name_high", 64'(m_tdata[71:64]), 64'(oldest_owed.name_high));
          if (m_tdata[79:72] !== oldest_owed.size)
            report_mismatch("out_size", 64'(m_tdata[79:72]), 64'(oldest_owed.size));
        end
      end
      if (s_tvalid && s_tready)
        owed_replies.push_back(serve_request(s_tuser, s_tdata[63:0], s_tdata[71:64],
                                             s_tdata[79:72]));
    end
    replies_owed <= owed_replies.size();
  end

endmodule

// File: verif/first_fit_wait_queue_unit_tb.sv
// testbench top for the first-fit wait queue unit: directed and random add and
// seat requests under varied idling; depends on ffwq_pkg, the dut and ffwq_reply_checker
module first_fit_wait_queue_unit_tb;

  localparam int   QUEUE_DEPTH = 16;
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_SEAT = 1'b1;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [ffwq_pkg::DATA_W-1:0]   s_tdata;
  logic                          s_tuser;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [ffwq_pkg::DATA_W-1:0]   m_tdata;
  logic [ffwq_pkg::STATUS_W-1:0] m_tuser;

  int          fail_count;
  int          replies_owed;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;
  logic        hold_request;
  logic [71:0] recent_names[32];

  first_fit_wait_queue_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  ffwq_reply_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) seat_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .replies_owed(replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stalls plus a long hold-off on request
  initial begin
    m_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) hold_left = 400;
      else if (hold_left != 0) hold_left--;
      m_tready <= (hold_left == 0) && !hold_request && ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  task automatic send_request(input logic seat, input logic [63:0] lo, input logic [7:0] hi,
                              input logic [7:0] amount);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {amount, hi, lo};
    s_tuser <= seat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_all_replies();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  // random length, nonzero bytes up to the end, sometimes junk after the terminator
  function automatic logic [71:0] random_name();
    logic [71:0] name;
    int          len;
    name = '0;
    len = $urandom_range(9, 0);
    for (int b = 0; b < 9; b++) begin
      if (b < len) name[8*b +: 8] = 8'($urandom_range(255, 1));
      else if (b > len && $urandom_range(3, 0) == 0) name[8*b +: 8] = 8'($urandom);
    end
    return name;
  endfunction

  task automatic random_request(input int add_pct);
    logic [71:0] name;
    logic [7:0]  amount;
    int          roll;
    roll = $urandom_range(9, 0);
    if ($urandom_range(99, 0) < add_pct) begin
      if ($urandom_range(99, 0) < 30) begin
        name = recent_names[$urandom_range(31, 0)];
      end else begin
        name = random_name();
        recent_names[$urandom_range(31, 0)] = name;
      end
      amount = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom);
      send_request(REQ_ADD, name[63:0], name[71:64], amount);
    end else begin
      name = {8'($urandom), $urandom, $urandom};
      amount = (roll < 2) ? 8'($urandom_range(15, 0)) : (roll == 2) ? 8'hFF : 8'($urandom);
      send_request(REQ_SEAT, name[63:0], name[71:64], amount);
    end
  endtask

  task automatic run_phase(input int count, input int idle, input int stall, input int add_pct);
    send_idle_pct = idle;
    recv_stall_pct <= stall;
    repeat (count) random_request(add_pct);
    wait_all_replies();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = REQ_ADD;
    hold_request = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (recent_names[i]) recent_names[i] = random_name();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty line, empty name, trimmed names, full line, duplicate while full
    send_request(REQ_SEAT, '0, '0, 8'hFF);
    send_request(REQ_ADD, '0, '0, 8'd5);
    send_request(REQ_ADD, 64'hA5C3_77E1_9B00_4241, 8'h5A, 8'd0);
    send_request(REQ_ADD, 64'h1234_5678_9A00_4241, 8'hFF, 8'd9);
    send_request(REQ_ADD, '1, 8'hFF, 8'hFF);
    send_request(REQ_SEAT, '1, 8'hFF, 8'd0);
    send_request(REQ_SEAT, '0, '0, 8'd4);
    for (int i = 0; i < 14; i++)
      send_request(REQ_ADD, 64'h41 | (64'(i + 1) << 8), '0, 8'(i * 18));
    send_request(REQ_ADD, 64'h7A, '0, 8'd1);
    send_request(REQ_ADD, '1, 8'hFF, 8'd3);
    send_request(REQ_SEAT, '0, '0, 8'hFF);
    send_request(REQ_SEAT, '0, '0, 8'hFF);
    wait_all_replies();

    // long receiver hold-off while the sender keeps offering
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    run_phase(300, 0, 0, 60);
    run_phase(300, 85, 0, 50);
    run_phase(300, 0, 85, 55);
    run_phase(300, 7, 7, 45);
    run_phase(200, 0, 0, 30);
    run_phase(300, 0, 0, 55);

    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
